[rtl/sawtc_pkg.sv]
// Shared types and codes for the stop-and-wait transaction controller.
package sawtc_pkg;

   localparam int SEQ_W     = 8;
   localparam int TICKS_W   = 16;
   localparam int TRIES_W   = 5;
   localparam int LIMIT_W   = 4;
   localparam int REASON_W  = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [1:0] {
      CMD_START_CTRL  = 2'd0,
      CMD_START_QUERY = 2'd1,
      CMD_FRAME       = 2'd2,
      CMD_TICK        = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      FK_REPORT    = 3'd0,
      FK_HEARTBEAT = 3'd1,
      FK_ACK       = 3'd2,
      FK_NAK       = 3'd3,
      FK_QUERY     = 3'd4,
      FK_OTHER     = 3'd5
   } frame_kind_type;

   typedef enum logic [1:0] {
      RK_SEND  = 2'd0,
      RK_DONE  = 2'd1,
      RK_EVENT = 2'd2
   } result_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NAK     = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_BUSY    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      WK_NONE   = 2'd0,
      WK_ACK    = 2'd1,
      WK_REPORT = 2'd2
   } wait_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RETRY_LIMIT   = 1'b0,
      CSR_TIMEOUT_TICKS = 1'b1
   } csr_index_type;

   typedef struct packed {
      cmd_type               cmd;
      frame_kind_type        frame_kind;
      logic [SEQ_W-1:0]      frame_seq;
      logic [REASON_W-1:0]   nak_reason;
   } item_type;

   typedef struct packed {
      result_kind_type       result_kind;
      logic [SEQ_W-1:0]      send_seq;
      logic                  send_is_query;
      logic [TRIES_W-1:0]    attempt;
      status_type            status;
      logic [REASON_W-1:0]   refuse_reason;
      logic                  event_kind;
   } result_type;

   typedef struct packed {
      logic ready;
      logic load;
   } out_hs_type;

endpackage

[rtl/sawtc_in_reg.sv]
// Input register: captures one request transfer and holds it until the controller takes it.
module sawtc_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_cmd,
   input  logic [2:0]            req_frame_kind,
   input  logic [7:0]            req_frame_seq,
   input  logic [7:0]            req_nak_reason,
   output sawtc_pkg::item_type   item,
   output logic                  item_valid,
   input  logic                  item_take
);
   import sawtc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_stall = valid_ff && !item_take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.cmd        <= cmd_type'(req_cmd);
         item_ff.frame_kind <= frame_kind_type'(req_frame_kind);
         item_ff.frame_seq  <= req_frame_seq;
         item_ff.nak_reason <= req_nak_reason;
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

[rtl/sawtc_ctrl.sv]
// Transaction state, configuration registers and per-item decision logic.
module sawtc_ctrl (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_write_enable,
   input  logic [sawtc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [sawtc_pkg::CSR_DAT_W-1:0]           csr_write_data,
   input  sawtc_pkg::item_type                       item,
   input  logic                                      item_valid,
   output logic                                      item_take,
   input  logic                                      out_ready,
   output sawtc_pkg::out_hs_type                     out_hs,
   output sawtc_pkg::result_type                     res
);
   import sawtc_pkg::*;

   logic [LIMIT_W-1:0] retry_limit_ff;
   logic [TICKS_W-1:0] timeout_ticks_ff;

   logic [SEQ_W-1:0]   next_seq_ff,   next_seq_in;
   wait_kind_type      wait_kind_ff,  wait_kind_in;
   logic [SEQ_W-1:0]   wait_seq_ff,   wait_seq_in;
   logic [TRIES_W-1:0] tries_done_ff, tries_done_in;
   logic [TICKS_W-1:0] ticks_left_ff, ticks_left_in;

   logic               pending;
   logic               match;
   logic               has_result;
   logic               fire;
   logic [TICKS_W-1:0] load_ticks;

   assign pending    = wait_kind_ff != WK_NONE;
   assign match      = pending && (item.frame_seq == wait_seq_ff);
   assign load_ticks = (timeout_ticks_ff == '0) ? TICKS_W'(1) : timeout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         retry_limit_ff   <= LIMIT_W'(3);
         timeout_ticks_ff <= TICKS_W'(100);
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_RETRY_LIMIT:   retry_limit_ff   <= csr_write_data[LIMIT_W-1:0];
            CSR_TIMEOUT_TICKS: timeout_ticks_ff <= csr_write_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      next_seq_in   = next_seq_ff;
      wait_kind_in  = wait_kind_ff;
      wait_seq_in   = wait_seq_ff;
      tries_done_in = tries_done_ff;
      ticks_left_in = ticks_left_ff;
      has_result    = 1'b0;
      res           = '0;
      case (item.cmd)
         CMD_START_CTRL, CMD_START_QUERY: begin
            has_result = 1'b1;
            if (pending) begin
               res.result_kind = RK_DONE;
               res.status      = ST_BUSY;
            end else begin
               wait_seq_in       = next_seq_ff;
               next_seq_in       = next_seq_ff + SEQ_W'(1);
               wait_kind_in      = (item.cmd == CMD_START_QUERY) ? WK_REPORT : WK_ACK;
               tries_done_in     = TRIES_W'(1);
               ticks_left_in     = load_ticks;
               res.result_kind   = RK_SEND;
               res.send_seq      = next_seq_ff;
               res.send_is_query = item.cmd == CMD_START_QUERY;
               res.attempt       = TRIES_W'(1);
            end
         end
         CMD_FRAME: begin
            case (item.frame_kind)
               FK_REPORT: begin
                  has_result = 1'b1;
                  if (match && wait_kind_ff == WK_REPORT) begin
                     wait_kind_in    = WK_NONE;
                     ticks_left_in   = '0;
                     res.result_kind = RK_DONE;
                     res.status      = ST_OK;
                  end else begin
                     res.result_kind = RK_EVENT;
                     res.event_kind  = 1'b0;
                  end
               end
               FK_HEARTBEAT: begin
                  has_result      = 1'b1;
                  res.result_kind = RK_EVENT;
                  res.event_kind  = 1'b1;
               end
               FK_ACK: begin
                  if (match && wait_kind_ff == WK_ACK) begin
                     has_result      = 1'b1;
                     wait_kind_in    = WK_NONE;
                     ticks_left_in   = '0;
                     res.result_kind = RK_DONE;
                     res.status      = ST_OK;
                  end
               end
               FK_NAK: begin
                  if (match) begin
                     has_result        = 1'b1;
                     wait_kind_in      = WK_NONE;
                     ticks_left_in     = '0;
                     res.result_kind   = RK_DONE;
                     res.status        = ST_NAK;
                     res.refuse_reason = item.nak_reason;
                  end
               end
               default: ;
            endcase
         end
         CMD_TICK: begin
            if (pending) begin
               if (ticks_left_ff > TICKS_W'(1)) begin
                  ticks_left_in = ticks_left_ff - TICKS_W'(1);
               end else if (tries_done_ff <= TRIES_W'(retry_limit_ff)) begin
                  has_result        = 1'b1;
                  tries_done_in     = tries_done_ff + TRIES_W'(1);
                  ticks_left_in     = load_ticks;
                  res.result_kind   = RK_SEND;
                  res.send_seq      = wait_seq_ff;
                  res.send_is_query = wait_kind_ff == WK_REPORT;
                  res.attempt       = tries_done_ff + TRIES_W'(1);
               end else begin
                  has_result      = 1'b1;
                  wait_kind_in    = WK_NONE;
                  ticks_left_in   = '0;
                  res.result_kind = RK_DONE;
                  res.status      = ST_TIMEOUT;
               end
            end
         end
         default: ;
      endcase
   end

   // advance when the result slot is free or the item yields nothing
   assign fire        = item_valid && (out_ready || !has_result);
   assign item_take   = fire;
   assign out_hs.ready = out_ready;
   assign out_hs.load = fire && has_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         next_seq_ff   <= '0;
         wait_kind_ff  <= WK_NONE;
         wait_seq_ff   <= '0;
         tries_done_ff <= '0;
         ticks_left_ff <= '0;
      end else if (fire) begin
         next_seq_ff   <= next_seq_in;
         wait_kind_ff  <= wait_kind_in;
         wait_seq_ff   <= wait_seq_in;
         tries_done_ff <= tries_done_in;
         ticks_left_ff <= ticks_left_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_no_timer: assert property (@(posedge clock) disable iff (reset)
      (wait_kind_ff == WK_NONE) |-> (ticks_left_ff == '0))
      else $error("timer running with no transaction pending");

   a_pending_timer: assert property (@(posedge clock) disable iff (reset)
      (wait_kind_ff != WK_NONE) |-> (ticks_left_ff != '0))
      else $error("pending transaction with expired timer");

   a_tries_range: assert property (@(posedge clock) disable iff (reset)
      (wait_kind_ff != WK_NONE) |-> (tries_done_ff >= TRIES_W'(1) &&
                                      tries_done_ff <= TRIES_W'(16)))
      else $error("try count out of range");

   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && !pending && (item.cmd == CMD_START_CTRL || item.cmd == CMD_START_QUERY))
      |=> (next_seq_ff == $past(next_seq_ff) + SEQ_W'(1)))
      else $error("sequence number not advanced on start");

   a_busy_keeps_seq: assert property (@(posedge clock) disable iff (reset)
      (fire && pending && (item.cmd == CMD_START_CTRL || item.cmd == CMD_START_QUERY))
      |=> $stable(next_seq_ff) && $stable(wait_seq_ff))
      else $error("busy start changed transaction state");
`endif

endmodule

[rtl/sawtc_out_reg.sv]
// Result register: holds one result until the receiver takes the transfer.
module sawtc_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  sawtc_pkg::result_type  res,
   input  sawtc_pkg::out_hs_type  out_hs,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_result_kind,
   output logic [7:0]             rsp_send_seq,
   output logic                   rsp_send_is_query,
   output logic [4:0]             rsp_attempt,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_refuse_reason,
   output logic                   rsp_event_kind
);
   import sawtc_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type res_ff;

   assign out_ready = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (out_hs.load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_hs.load && out_hs.ready) begin
         res_ff <= res;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = res_ff.result_kind;
   assign rsp_send_seq      = res_ff.send_seq;
   assign rsp_send_is_query = res_ff.send_is_query;
   assign rsp_attempt       = res_ff.attempt;
   assign rsp_status        = res_ff.status;
   assign rsp_refuse_reason = res_ff.refuse_reason;
   assign rsp_event_kind    = res_ff.event_kind;

endmodule

[rtl/stop_and_wait_transaction_control.sv]
// Stop-and-wait sender: one transaction at a time with sequence numbers, timeout and resends.
// Each request transfer lands in an input register; from there the controller decides
// on it with a few compares and counter updates, updates the transaction state and, when the
// item yields a result, loads the result register, which holds it until the receiver takes it.
// One request is taken every cycle while req_stall is low; the input register keeps taking
// requests while a result waits under stall, and only stops once the item it holds needs
// the occupied result slot. Items that yield no result (idle ticks, countdown ticks,
// unmatched acks) never wait on the result side. Write retry_limit (index 0) and
// timeout_ticks (index 1, zero acts as one) only while no transfer is in flight.
module stop_and_wait_transaction_control (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [2:0] req_frame_kind,
   input  logic [7:0] req_frame_seq,
   input  logic [7:0] req_nak_reason,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_send_seq,
   output logic       rsp_send_is_query,
   output logic [4:0] rsp_attempt,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_refuse_reason,
   output logic       rsp_event_kind,
   input  logic       csr_write_enable,
   input  logic [0:0] csr_index,
   input  logic [15:0] csr_write_data
);
   import sawtc_pkg::*;

   item_type   item;
   logic       item_valid;
   out_hs_type out_hs;
   result_type res;
   logic       out_ready;
   logic       item_take;

   sawtc_in_reg u_in_reg (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_frame_kind (req_frame_kind),
      .req_frame_seq  (req_frame_seq),
      .req_nak_reason (req_nak_reason),
      .item           (item),
      .item_valid     (item_valid),
      .item_take      (item_take)
   );

   sawtc_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .item_valid       (item_valid),
      .item_take        (item_take),
      .out_ready        (out_ready),
      .out_hs           (out_hs),
      .res              (res)
   );

   sawtc_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .res               (res),
      .out_hs            (out_hs),
      .out_ready         (out_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_send_seq      (rsp_send_seq),
      .rsp_send_is_query (rsp_send_is_query),
      .rsp_attempt       (rsp_attempt),
      .rsp_status        (rsp_status),
      .rsp_refuse_reason (rsp_refuse_reason),
      .rsp_event_kind    (rsp_event_kind)
   );

endmodule
